### hdl/frs_pkg.sv
// frs_pkg: shared types and constants for the frame record reassembler.
// Used by frs_front, frs_queue, frs_back and frame_struct_reassembler.
package frs_pkg;

    localparam int unsigned NUM_IDS_DEF   = 8;
    localparam int unsigned FRAME_BYTES   = 8;
    localparam int unsigned PAYLOAD_MAX   = 7;
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned ID_W          = 3;
    localparam int unsigned LEN_W         = 8;
    localparam int unsigned CNT_W         = 3;
    localparam int unsigned KIND_W        = 2;
    localparam int unsigned CFG_ADDR_W    = 1;
    localparam int unsigned CFG_DATA_W    = 64;
    localparam int unsigned IN_DATA_W     = FRAME_BYTES * BYTE_W;
    localparam int unsigned OUT_DATA_W    = 72;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_HEADER_CODE = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SIZE_TABLE  = 1'b1;

    // result kind reported on the output channel
    typedef enum logic [KIND_W-1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_IGNORED = 2'd2
    } t_kind;

    // frame class decided by the front end
    typedef enum logic [1:0] {
        CLS_START = 2'd0,   // header with a valid id
        CLS_DROP  = 2'd1,   // header with an id out of range
        CLS_DATA  = 2'd2    // anything else: candidate payload
    } t_cls;

    typedef logic [PAYLOAD_MAX-1:0][BYTE_W-1:0] t_bytes;

    // classified frame held in the queue
    typedef struct packed {
        t_cls              cls;
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  len;
        t_bytes            bytes;
    } t_cmd;

endpackage

### hdl/frame_struct_reassembler.sv
// frame_struct_reassembler: top level of the frame record reassembler.
// Instantiates frs_front, frs_queue and frs_back; depends on frs_pkg.
//
// Usage:
//   Frames of eight bytes enter on the slave stream (i_s_*), byte0 in the
//   lowest bits of i_s_tdata. A frame whose byte0 matches the header code
//   starts a record whose length comes from the packed size table; other
//   frames deliver up to seven payload bytes until the record is full.
//   Every frame yields exactly one result item on the master stream (o_m_*):
//   tuser carries the kind (header, payload, ignored), tlast marks the item
//   that completed the record, tdata the id, offset, count and bytes. The
//   consumer keeps the partial record and commits it on tlast.
//   Configuration (header code, size table) is written through i_cfg_* while
//   the stream is idle; each write takes effect at the next clock.
// Timing:
//   One item per cycle sustained while i_m_tready stays high. The front end
//   classifies a frame combinationally in its accept cycle, the frame is then
//   registered in a two-entry queue, and the back end updates the record state
//   and loads the output register together when it pops the frame.
// Reset and stalls:
//   Synchronous active-low reset clears configuration and record state and
//   empties the queue and output register. When the receiver holds tready
//   low, the result holds, the queue fills, then o_s_tready drops.
module frame_struct_reassembler #(
    parameter int unsigned NUM_IDS = frs_pkg::NUM_IDS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [frs_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [frs_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // input frames
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // byte0[7:0], byte1 .. byte7 upward, 8 bits each
    input  logic [frs_pkg::IN_DATA_W-1:0]      i_s_tdata,
    // result items
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // record_id[2:0], offset[10:3], count[13:11], out1..out7 from bit 14 up, zero pad
    output logic [frs_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    // kind[1:0]
    output logic [frs_pkg::KIND_W-1:0]         o_m_tuser,
    // done_res
    output logic                               o_m_tlast
);

    localparam int unsigned PAD_W = frs_pkg::OUT_DATA_W - frs_pkg::ID_W - frs_pkg::LEN_W
                                    - frs_pkg::CNT_W - frs_pkg::PAYLOAD_MAX * frs_pkg::BYTE_W;

    frs_pkg::t_cmd              front_cmd;
    frs_pkg::t_cmd              head_cmd;
    logic                       q_ready;
    logic                       q_valid;
    logic                       push;
    logic                       pop;

    frs_pkg::t_kind             res_kind;
    logic [frs_pkg::ID_W-1:0]   res_id;
    logic [frs_pkg::LEN_W-1:0]  res_offset;
    logic [frs_pkg::CNT_W-1:0]  res_count;
    frs_pkg::t_bytes            res_bytes;

    // accept a frame whenever the queue has a free entry
    assign o_s_tready = q_ready;
    assign push       = i_s_tvalid && q_ready;

    frs_front #(
        .NUM_IDS (NUM_IDS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_frame     (i_s_tdata),
        .o_cmd       (front_cmd)
    );

    frs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    frs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (head_cmd),
        .o_cmd_pop   (pop),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_kind      (res_kind),
        .o_id        (res_id),
        .o_offset    (res_offset),
        .o_count     (res_count),
        .o_bytes     (res_bytes),
        .o_done      (o_m_tlast)
    );

    // pack the result; out1 sits just above count
    assign o_m_tdata = {{PAD_W{1'b0}}, res_bytes, res_count, res_offset, res_id};
    assign o_m_tuser = res_kind;

endmodule

### hdl/frs_front.sv
// frs_front: configuration registers and frame classification.
// Depends on frs_pkg.
module frs_front #(
    parameter int unsigned NUM_IDS = frs_pkg::NUM_IDS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [frs_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [frs_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic [frs_pkg::IN_DATA_W-1:0]       i_frame,
    output frs_pkg::t_cmd                       o_cmd
);

    logic [frs_pkg::BYTE_W-1:0]     r_header_code;
    logic [frs_pkg::CFG_DATA_W-1:0] r_size_table;

    logic [frs_pkg::BYTE_W-1:0]     byte0;
    logic [frs_pkg::BYTE_W-1:0]     byte1;
    logic                           is_header;
    logic                           id_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_code <= '0;
            r_size_table  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                frs_pkg::CFG_HEADER_CODE: r_header_code <= i_cfg_wdata[frs_pkg::BYTE_W-1:0];
                frs_pkg::CFG_SIZE_TABLE:  r_size_table  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign byte0     = i_frame[frs_pkg::BYTE_W-1:0];
    assign byte1     = i_frame[2*frs_pkg::BYTE_W-1:frs_pkg::BYTE_W];
    assign is_header = (byte0 == r_header_code);
    assign id_ok     = (byte1 < frs_pkg::BYTE_W'(NUM_IDS));

    always_comb begin
        o_cmd.id    = byte1[frs_pkg::ID_W-1:0];
        o_cmd.len   = r_size_table[{o_cmd.id, 3'b000} +: frs_pkg::LEN_W];
        o_cmd.bytes = i_frame[frs_pkg::IN_DATA_W-1:frs_pkg::BYTE_W];
        if (!is_header) begin
            o_cmd.cls = frs_pkg::CLS_DATA;
        end else if (id_ok) begin
            o_cmd.cls = frs_pkg::CLS_START;
        end else begin
            o_cmd.cls = frs_pkg::CLS_DROP;
        end
    end

endmodule

### hdl/frs_queue.sv
// frs_queue: two-entry queue of classified frames between front and back.
// Depends on frs_pkg.
module frs_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  frs_pkg::t_cmd i_cmd,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output frs_pkg::t_cmd o_cmd
);

    frs_pkg::t_cmd r_head;
    frs_pkg::t_cmd r_tail;
    logic          r_head_v;
    logic          r_tail_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_v <= 1'b0;
            r_tail_v <= 1'b0;
        end else if (i_pop) begin
            if (r_tail_v) begin
                r_head_v <= 1'b1;
                r_tail_v <= i_push;
            end else begin
                r_head_v <= i_push;
            end
        end else if (i_push) begin
            if (r_head_v) begin
                r_tail_v <= 1'b1;
            end else begin
                r_head_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pop) begin
            if (r_tail_v) begin
                r_head <= r_tail;
                if (i_push) begin
                    r_tail <= i_cmd;
                end
            end else if (i_push) begin
                r_head <= i_cmd;
            end
        end else if (i_push) begin
            if (r_head_v) begin
                r_tail <= i_cmd;
            end else begin
                r_head <= i_cmd;
            end
        end
    end

    assign o_ready = !r_tail_v;
    assign o_valid = r_head_v;
    assign o_cmd   = r_head;

endmodule

### hdl/frs_back.sv
// frs_back: record state and result register; executes classified frames.
// Depends on frs_pkg.
module frs_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  frs_pkg::t_cmd                 i_cmd,
    output logic                          o_cmd_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output frs_pkg::t_kind                o_kind,
    output logic [frs_pkg::ID_W-1:0]      o_id,
    output logic [frs_pkg::LEN_W-1:0]     o_offset,
    output logic [frs_pkg::CNT_W-1:0]     o_count,
    output frs_pkg::t_bytes               o_bytes,
    output logic                          o_done
);

    logic [frs_pkg::ID_W-1:0]  r_active_id;
    logic [frs_pkg::LEN_W-1:0] r_exp_len;
    logic [frs_pkg::LEN_W-1:0] r_rcv_len;

    logic                      r_out_v;
    frs_pkg::t_kind            r_kind;
    logic [frs_pkg::ID_W-1:0]  r_id;
    logic [frs_pkg::LEN_W-1:0] r_offset;
    logic [frs_pkg::CNT_W-1:0] r_count;
    frs_pkg::t_bytes           r_bytes;
    logic                      r_done;

    logic                      slot_free;
    logic [frs_pkg::LEN_W-1:0] missing;
    logic [frs_pkg::CNT_W-1:0] take_cnt;
    logic [frs_pkg::LEN_W-1:0] n_rcv_len;
    frs_pkg::t_bytes           masked;
    logic                      is_data;

    assign slot_free = !r_out_v || i_ready;
    assign o_cmd_pop = i_cmd_valid && slot_free;

    assign missing   = r_exp_len - r_rcv_len;
    assign take_cnt  = (missing < frs_pkg::LEN_W'(frs_pkg::PAYLOAD_MAX))
                       ? missing[frs_pkg::CNT_W-1:0] : frs_pkg::CNT_W'(frs_pkg::PAYLOAD_MAX);
    assign n_rcv_len = r_rcv_len + frs_pkg::LEN_W'(take_cnt);
    assign is_data   = (i_cmd.cls == frs_pkg::CLS_DATA) && (r_rcv_len != r_exp_len);

    always_comb begin
        for (int i = 0; i < frs_pkg::PAYLOAD_MAX; i++) begin
            masked[i] = (frs_pkg::CNT_W'(i) < take_cnt) ? i_cmd.bytes[i] : '0;
        end
    end

    // record state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_id <= '0;
            r_exp_len   <= '0;
            r_rcv_len   <= '0;
            r_out_v     <= 1'b0;
        end else begin
            if (o_cmd_pop) begin
                r_out_v <= 1'b1;
                if (i_cmd.cls == frs_pkg::CLS_START) begin
                    r_active_id <= i_cmd.id;
                    r_exp_len   <= i_cmd.len;
                    r_rcv_len   <= '0;
                end else if (is_data) begin
                    r_rcv_len <= n_rcv_len;
                end
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            if (i_cmd.cls == frs_pkg::CLS_START) begin
                r_kind   <= frs_pkg::KIND_HEADER;
                r_id     <= i_cmd.id;
                r_offset <= '0;
                r_count  <= '0;
                r_bytes  <= '0;
                r_done   <= 1'b0;
            end else if (is_data) begin
                r_kind   <= frs_pkg::KIND_PAYLOAD;
                r_id     <= r_active_id;
                r_offset <= r_rcv_len;
                r_count  <= take_cnt;
                r_bytes  <= masked;
                r_done   <= (n_rcv_len == r_exp_len);
            end else begin
                r_kind   <= frs_pkg::KIND_IGNORED;
                r_id     <= r_active_id;
                r_offset <= r_rcv_len;
                r_count  <= '0;
                r_bytes  <= '0;
                r_done   <= 1'b0;
            end
        end
    end

    assign o_valid  = r_out_v;
    assign o_kind   = r_kind;
    assign o_id     = r_id;
    assign o_offset = r_offset;
    assign o_count  = r_count;
    assign o_bytes  = r_bytes;
    assign o_done   = r_done;

    // received count never passes the expected length
    a_rcv_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rcv_len <= r_exp_len)
        else $error("received length beyond expected length");

    // only payload results carry bytes or completion
    a_cnt_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_kind != frs_pkg::KIND_PAYLOAD) |-> (r_count == '0 && !r_done))
        else $error("non-payload result carries data");

    // a started record restarts the byte count
    a_start_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_pop && i_cmd.cls == frs_pkg::CLS_START) |=> (r_rcv_len == '0))
        else $error("header did not clear received length");

    // a payload result advances the count by exactly the bytes delivered
    a_rcv_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_pop && is_data) |=>
            (r_rcv_len == r_offset + frs_pkg::LEN_W'(r_count)))
        else $error("received length out of step with result");

endmodule

### bench/tb_top.sv
// tb_top: self-checking bench for frame_struct_reassembler (hdl/frs_pkg.sv and top level).
// Tracks the record state alongside the block, compares every result item field by
// field, and runs directed frames followed by random record sequences under stalls.
module tb_top;
    import frs_pkg::*;

    localparam int unsigned NUM_IDS        = NUM_IDS_DEF;
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned MAX_REPORTS    = 10;

    // One expected result item, unpacked.
    typedef struct {
        t_kind             kind;
        logic [ID_W-1:0]   record_id;
        logic [LEN_W-1:0]  offset;
        logic [CNT_W-1:0]  count;
        t_bytes            bytes;
        logic              done;
    } record_result_t;

    // Mirrors the record state of the block and holds the results still owed.
    class record_tracker;
        logic [BYTE_W-1:0]     header_code;
        logic [CFG_DATA_W-1:0] size_table;
        logic [ID_W-1:0]       active_id;
        logic [LEN_W-1:0]      expected_len;
        logic [LEN_W-1:0]      received_len;
        record_result_t        pending_results[$];
        int unsigned           mismatches;
        int unsigned           results_seen;

        function new();
            header_code  = '0;
            size_table   = '0;
            active_id    = '0;
            expected_len = '0;
            received_len = '0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void set_register(logic [CFG_ADDR_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            if (index == CFG_HEADER_CODE) begin
                header_code = value[BYTE_W-1:0];
            end else if (index == CFG_SIZE_TABLE) begin
                size_table = value;
            end
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        // Update the record state for one accepted frame and queue its result.
        function void note_frame(logic [IN_DATA_W-1:0] frame);
            record_result_t    res;
            logic [BYTE_W-1:0] id_byte;
            logic [LEN_W-1:0]  missing;
            int unsigned       take;
            id_byte    = frame[15:8];
            res.kind   = KIND_IGNORED;
            res.offset = received_len;
            res.count  = '0;
            res.bytes  = '0;
            res.done   = 1'b0;
            if (frame[7:0] == header_code) begin
                // out-of-range ids leave the record untouched
                if (id_byte < NUM_IDS) begin
                    active_id    = id_byte[ID_W-1:0];
                    expected_len = size_table[8*id_byte +: 8];
                    received_len = '0;
                    res.kind     = KIND_HEADER;
                    res.offset   = '0;
                end
            end else if (received_len != expected_len) begin
                missing = expected_len - received_len;
                take    = (missing < PAYLOAD_MAX) ? 32'(missing) : PAYLOAD_MAX;
                for (int i = 0; i < take; i++) begin
                    res.bytes[i] = frame[8*(i+1) +: 8];
                end
                received_len = received_len + LEN_W'(take);
                res.count    = CNT_W'(take);
                res.done     = (received_len == expected_len);
                res.kind     = KIND_PAYLOAD;
            end
            res.record_id = active_id;
            pending_results.push_back(res);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("mismatch: %s", msg);
            end
        endfunction

        function void compare_field(string field, longint unsigned want, longint unsigned got);
            if (want != got) begin
                flag($sformatf("result %0d %s: expected 0x%0h, got 0x%0h",
                               results_seen, field, want, got));
            end
        endfunction

        // Compare one accepted result item against the oldest one owed.
        function void check_result(logic [OUT_DATA_W-1:0] data, logic [KIND_W-1:0] user,
                                   logic last);
            record_result_t want;
            results_seen++;
            if (pending_results.size() == 0) begin
                flag($sformatf("result %0d arrived with nothing owed", results_seen));
                return;
            end
            want = pending_results.pop_front();
            compare_field("kind", 64'(want.kind), 64'(user));
            compare_field("record_id", 64'(want.record_id), 64'(data[2:0]));
            compare_field("offset", 64'(want.offset), 64'(data[10:3]));
            compare_field("count", 64'(want.count), 64'(data[13:11]));
            for (int i = 0; i < PAYLOAD_MAX; i++) begin
                compare_field($sformatf("out%0d", i + 1), 64'(want.bytes[i]),
                              64'(data[14+8*i +: 8]));
            end
            compare_field("pad", 64'd0, 64'(data[OUT_DATA_W-1:70]));
            compare_field("done_res", 64'(want.done), 64'(last));
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    // byte0[7:0], byte1[15:8] .. byte7[63:56]
    logic [IN_DATA_W-1:0]  i_s_tdata   = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    // record_id[2:0], offset[10:3], count[13:11], out1..out7 from bit 14, zero pad
    logic [OUT_DATA_W-1:0] o_m_tdata;
    // kind[1:0]
    logic [KIND_W-1:0]     o_m_tuser;
    // done_res
    logic                  o_m_tlast;

    record_tracker tracker = new();

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned frames_sent    = 0;
    int unsigned idle_cycles    = 0;

    frame_struct_reassembler #(
        .NUM_IDS (NUM_IDS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Receiver: stall at random at the rate of the current phase.
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor both streams. Check the result before noting the frame so that an
    // item accepted on the same edge never meets its own expectation.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                tracker.check_result(o_m_tdata, o_m_tuser, o_m_tlast);
            end
            if (i_s_tvalid && o_s_tready) begin
                tracker.note_frame(i_s_tdata);
            end
        end
    end

    // Watchdog: end the run when nothing moves on either stream for too long.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Build a frame that is not a header under the current header code.
    function automatic logic [IN_DATA_W-1:0] data_frame(input logic [55:0] body);
        logic [BYTE_W-1:0] first;
        first = 8'($urandom);
        if (first == tracker.header_code) begin
            first = ~first;
        end
        return {body, first};
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_data_frame();
        return data_frame(56'({$urandom, $urandom}));
    endfunction

    // Header frame for the given id byte; the trailing bytes are noise.
    function automatic logic [IN_DATA_W-1:0] header_frame(input logic [BYTE_W-1:0] id);
        logic [IN_DATA_W-1:0] f;
        f       = {$urandom, $urandom};
        f[7:0]  = tracker.header_code;
        f[15:8] = id;
        return f;
    endfunction

    // Size table with short records, some of them empty.
    function automatic logic [CFG_DATA_W-1:0] short_sizes();
        logic [CFG_DATA_W-1:0] s;
        for (int i = 0; i < 8; i++) begin
            s[8*i +: 8] = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(30));
        end
        return s;
    endfunction

    // Offer one frame and hold it until accepted. Leave tvalid high on return so
    // that back-to-back items never lower and raise it within one step.
    task automatic send_frame(input logic [IN_DATA_W-1:0] frame);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= frame;
        do @(posedge i_clk); while (!o_s_tready);
        frames_sent++;
    endtask

    // Stop sending and wait until every owed result has come out.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (2) @(posedge i_clk);
    endtask

    // Write both registers back to back; call only while the block is idle.
    task automatic write_config(input logic [BYTE_W-1:0] code,
                                input logic [CFG_DATA_W-1:0] sizes);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_HEADER_CODE;
        i_cfg_wdata <= CFG_DATA_W'(code);
        @(posedge i_clk);
        i_cfg_addr  <= CFG_SIZE_TABLE;
        i_cfg_wdata <= sizes;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.set_register(CFG_HEADER_CODE, CFG_DATA_W'(code));
        tracker.set_register(CFG_SIZE_TABLE, sizes);
    endtask

    // Random traffic: mostly complete records with random content, the rest
    // bad headers, stray payload, raw noise and records cut short.
    task automatic run_random(input int unsigned n_frames);
        int unsigned stop_at;
        int unsigned id;
        int unsigned len;
        int unsigned n_payload;
        int unsigned pick;
        stop_at = frames_sent + n_frames;
        while (frames_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                send_frame(header_frame(8'($urandom_range(255, NUM_IDS))));
            end else if (pick < 12) begin
                send_frame(random_data_frame());
            end else if (pick < 15) begin
                send_frame({$urandom, $urandom});
            end else begin
                id        = $urandom_range(NUM_IDS - 1);
                len       = 32'(tracker.size_table[8*id +: 8]);
                n_payload = (len + PAYLOAD_MAX - 1) / PAYLOAD_MAX;
                // cut some records short; the next header restarts mid-record
                if ($urandom_range(99) < 8) begin
                    n_payload = $urandom_range(n_payload);
                end
                send_frame(header_frame(8'(id)));
                repeat (n_payload) send_frame(random_data_frame());
                // trailing payload after the record is complete
                if ($urandom_range(99) < 10) begin
                    send_frame(random_data_frame());
                end
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset config: header code 0, every size 0.
        send_frame(data_frame(56'd0));                  // payload right after reset
        send_frame(header_frame(8'd3));                 // header of an empty record
        send_frame(data_frame({56{1'b1}}));             // payload to an empty record
        send_frame(header_frame(8'd8));                 // first id out of range
        drain();

        // Sizes by id: 7, 1, 20, 0, 14, 8, 0, 255.
        write_config(8'hA5, 64'hFF00_080E_0014_0107);
        send_frame(header_frame(8'd0));
        send_frame(data_frame({56{1'b1}}));             // full frame completes
        send_frame(random_data_frame());                // payload after completion
        send_frame(header_frame(8'd2));
        send_frame(data_frame(56'd0));
        send_frame(data_frame({56{1'b1}}));
        send_frame(random_data_frame());                // short last payload
        send_frame(header_frame(8'd255));               // largest id byte, ignored
        send_frame(header_frame(8'd1));
        send_frame(random_data_frame());                // single byte record
        send_frame(header_frame(8'd7));
        send_frame(random_data_frame());
        send_frame(header_frame(8'd4));                 // restart mid-record
        send_frame(random_data_frame());
        send_frame(random_data_frame());
        send_frame(header_frame(8'd6));
        send_frame(random_data_frame());
        drain();

        // Phase 0: no idling on either side.
        write_config(8'hFF, short_sizes());
        run_random(395);
        drain();

        // Phase 1: sender idles, longest records.
        send_idle_pct = 55;
        write_config(8'($urandom), {CFG_DATA_W{1'b1}});
        run_random(395);
        drain();

        // Phase 2: receiver stalls, fully random sizes.
        send_idle_pct  = 0;
        recv_stall_pct = 55;
        write_config(8'h00, {$urandom, $urandom});
        run_random(395);
        drain();

        // Phase 3: both sides idle.
        send_idle_pct  = 38;
        recv_stall_pct = 38;
        write_config(8'($urandom), short_sizes());
        run_random(395);
        drain();

        repeat (10) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/frs_pkg.sv
hdl/frs_front.sv
hdl/frs_queue.sv
hdl/frs_back.sv
hdl/frame_struct_reassembler.sv
bench/tb_top.sv
